/* rtl/bbst_pkg.sv */
// Shared types, constants and helper functions of the balanced tree builder.
package bbst_pkg;

  localparam int KEY_W = 32;
  localparam int CNT_W = 6;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic                    last_key;
  } in_t;

  typedef struct packed {
    logic [CNT_W-1:0]        slot;
    logic signed [KEY_W-1:0] node_key;
    logic                    present;
    logic                    last_slot;
  } out_t;

  typedef struct packed {
    logic             we;
    logic [CNT_W-1:0] waddr;
    logic [KEY_W-1:0] wdata;
    logic [CNT_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic             present;
    logic [CNT_W-1:0] idx;
  } walk_res_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_WALK,
    ST_FETCH
  } top_st_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_VGET,
    S_CMP,
    S_PUT,
    S_DONE
  } sort_st_e;

  typedef enum logic {
    W_IDLE,
    W_STEP
  } walk_st_e;

  function automatic logic [CNT_W-1:0] fill_below(logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] a;
    logic [CNT_W-1:0] b;
    a = v | (v >> 1);
    b = a | (a >> 2);
    return b | (b >> 4);
  endfunction

  function automatic logic [2:0] msb_pos(logic [CNT_W-1:0] v);
    logic [2:0] p;
    p = '0;
    for (int k = 0; k < CNT_W; k++) begin
      if (v[k]) begin
        p = 3'(k);
      end
    end
    return p;
  endfunction

endpackage

/* rtl/balanced_bst_level_order_builder_top.sv */
// Top level of the balanced tree builder: key load, sort and level-order emit.
//
// Input channel (in_valid_i, in_stall_o, in_data_i) takes one signed key per
// transfer, one per cycle while loading. Keys beyond MAX_KEYS are dropped.
// A key with last_key set closes the set; in_stall_o then stays high until
// the whole tree array has been handed out.
// Sort: insertion sort in the key RAM, one compare per cycle on the shared
// comparator; each key is read, then compared against the keys to its left,
// which move up one place, until its position is found and it is written.
// Emit: 2^(floor(log2 n)+1)-1 results on the output channel (out_valid_o,
// out_stall_i, out_data_o) in slot order. For a slot at tree level L (root at
// level 0) the walker descends L levels from the root, then the fetch state
// loads the output register from the RAM.
// The output register holds a result while out_stall_i is high and the
// emitter waits; a new set may be loaded while the last result still waits.
// Reset clears the key count, the sequencers and the output valid; the key
// RAM is not cleared.
module balanced_bst_level_order_builder_top
  import bbst_pkg::*;
#(
  parameter int MAX_KEYS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

  top_st_e state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] slot_q, slot_d;
  logic [CNT_W-1:0] last_q, last_d;
  logic             out_valid_q, out_valid_d;
  out_t             out_q, out_d;

  logic             accept;
  logic             room;
  logic             out_free;
  logic             final_slot;
  logic             sort_start;
  logic             sort_done;
  ram_req_t         sort_req;
  logic             walk_start;
  logic             walk_done;
  walk_res_t        walk_res;
  ram_req_t         ram_req;
  logic [KEY_W-1:0] ram_rdata;

  assign in_stall_o = (state_q != ST_LOAD);
  assign accept     = in_valid_i && !in_stall_o;
  assign room       = count_q < CNT_W'(MAX_KEYS);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign final_slot = (slot_q == last_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD:  state_d = (accept && in_data_i.last_key) ? ST_SORT : ST_LOAD;
      ST_SORT:  state_d = sort_done ? ST_WALK : ST_SORT;
      ST_WALK:  state_d = walk_done ? ST_FETCH : ST_WALK;
      ST_FETCH: begin
        if (out_free) begin
          state_d = final_slot ? ST_LOAD : ST_WALK;
        end
      end
      default:  state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    count_d     = count_q;
    slot_d      = slot_q;
    last_d      = last_q;
    sort_start  = 1'b0;
    walk_start  = 1'b0;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_req     = '0;
    ram_req.raddr = walk_res.idx;
    case (state_q)
      ST_LOAD: begin
        ram_req.waddr = count_q;
        ram_req.wdata = in_data_i.key;
        if (accept) begin
          ram_req.we = room;
          if (room) begin
            count_d = count_q + CNT_W'(1);
          end
          sort_start = in_data_i.last_key;
        end
      end
      ST_SORT: begin
        ram_req = sort_req;
        if (sort_done) begin
          last_d     = fill_below(count_q) - CNT_W'(1);
          slot_d     = '0;
          walk_start = 1'b1;
        end
      end
      ST_FETCH: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.slot        = slot_q;
          out_d.present     = walk_res.present;
          out_d.node_key    = walk_res.present ? ram_rdata : '0;
          out_d.last_slot   = final_slot;
          if (final_slot) begin
            count_d = '0;
          end else begin
            slot_d     = slot_q + CNT_W'(1);
            walk_start = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  bbst_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_KEYS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr[AW-1:0]),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  bbst_sort u_sort (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sort_start),
    .n_i     (count_d),
    .rdata_i (ram_rdata),
    .req_o   (sort_req),
    .done_o  (sort_done)
  );

  bbst_walk u_walk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (walk_start),
    .n_i     (count_q),
    .slot_i  (slot_d),
    .done_o  (walk_done),
    .res_o   (walk_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    last_q <= last_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_KEYS))
    else $error("key count above capacity");

  a_sort_done_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sort_done |-> state_q == ST_SORT)
    else $error("sort completion outside sort phase");

  a_node_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FETCH && walk_res.present) |-> walk_res.idx < count_q)
    else $error("tree node index beyond key count");

  a_load_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q || !out_stall_i) && out_valid_d |-> state_q == ST_FETCH)
    else $error("output register loaded outside fetch phase");

endmodule

/* rtl/bbst_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bbst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/bbst_sort.sv */
// Insertion sort sequencer over the key RAM with one shared signed comparator.
module bbst_sort
  import bbst_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [CNT_W-1:0]        n_i,
  input  logic signed [KEY_W-1:0] rdata_i,
  output ram_req_t                req_o,
  output logic                    done_o
);

  sort_st_e state_q, state_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic [CNT_W-1:0] i_q, i_d;
  logic [CNT_W-1:0] j_q, j_d;
  logic signed [KEY_W-1:0] v_q, v_d;
  logic less;
  logic more_left;

  assign less      = v_q < rdata_i;
  assign more_left = (i_q + CNT_W'(1)) < n_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = (n_i > CNT_W'(1)) ? S_FETCH : S_DONE;
        end
      end
      S_FETCH: state_d = S_VGET;
      S_VGET:  state_d = S_CMP;
      S_CMP: begin
        if (less) begin
          state_d = (j_q == CNT_W'(1)) ? S_PUT : S_CMP;
        end else begin
          state_d = more_left ? S_FETCH : S_DONE;
        end
      end
      S_PUT:   state_d = more_left ? S_FETCH : S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    n_d   = n_q;
    i_d   = i_q;
    j_d   = j_q;
    v_d   = v_q;
    req_o = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          n_d = n_i;
          i_d = CNT_W'(1);
        end
      end
      S_FETCH: begin
        req_o.raddr = i_q;
      end
      S_VGET: begin
        v_d         = rdata_i;
        j_d         = i_q;
        req_o.raddr = i_q - CNT_W'(1);
      end
      S_CMP: begin
        req_o.we    = 1'b1;
        req_o.waddr = j_q;
        if (less) begin
          req_o.wdata = rdata_i;
          j_d         = j_q - CNT_W'(1);
          req_o.raddr = (j_q == CNT_W'(1)) ? '0 : j_q - CNT_W'(2);
        end else begin
          req_o.wdata = v_q;
          i_d         = i_q + CNT_W'(1);
        end
      end
      S_PUT: begin
        req_o.we    = 1'b1;
        req_o.waddr = '0;
        req_o.wdata = v_q;
        i_d         = i_q + CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  assign done_o = (state_q == S_DONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d;
    i_q <= i_d;
    j_q <= j_d;
    v_q <= v_d;
  end

endmodule

/* rtl/bbst_walk.sv */
// Path walker: derives the sorted index held by one level-order slot.
module bbst_walk
  import bbst_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [CNT_W-1:0] n_i,
  input  logic [CNT_W-1:0] slot_i,
  output logic             done_o,
  output walk_res_t        res_o
);

  walk_st_e state_q, state_d;
  logic [CNT_W-1:0] lo_q, lo_d;
  logic [CNT_W-1:0] size_q, size_d;
  logic [CNT_W-1:0] path_q, path_d;
  logic [2:0]       pos_q, pos_d;
  logic [CNT_W-1:0] half;
  logic [CNT_W-1:0] path_init;
  logic             go_right;

  assign half      = size_q >> 1;
  assign path_init = slot_i + CNT_W'(1);
  assign go_right  = path_q[pos_q - 3'd1];

  always_comb begin
    state_d = state_q;
    if (start_i) begin
      state_d = W_STEP;
    end else begin
      case (state_q)
        W_IDLE:  state_d = W_IDLE;
        W_STEP:  state_d = (pos_q == 3'd0) ? W_IDLE : W_STEP;
        default: state_d = W_IDLE;
      endcase
    end
  end

  always_comb begin
    lo_d   = lo_q;
    size_d = size_q;
    path_d = path_q;
    pos_d  = pos_q;
    if (start_i) begin
      lo_d   = '0;
      size_d = n_i;
      path_d = path_init;
      pos_d  = msb_pos(path_init);
    end else if (state_q == W_STEP && pos_q != 3'd0) begin
      pos_d = pos_q - 3'd1;
      if (size_q != '0) begin
        if (go_right) begin
          lo_d   = lo_q + half + CNT_W'(1);
          size_d = size_q - half - CNT_W'(1);
        end else begin
          size_d = half;
        end
      end
    end
  end

  assign done_o        = (state_q == W_STEP) && (pos_q == 3'd0);
  assign res_o.present = (size_q != '0);
  assign res_o.idx     = lo_q + half;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    size_q <= size_d;
    path_q <= path_d;
    pos_q  <= pos_d;
  end

endmodule

/* tb/sv/balanced_bst_level_order_builder_top_test.sv */
// Self-checking testbench of the balanced tree builder: directed and random key sets against a tree predictor.
module balanced_bst_level_order_builder_top_test;
  import bbst_pkg::*;

  localparam int KEY_SLOTS   = 32;
  localparam int SLOT_LIMIT  = 63;
  localparam int ITEM_TARGET = 280;
  localparam int IDLE_LIMIT  = 20000;
  localparam int HOLD_CYCLES = 600;
  localparam int END_GUARD   = 100;
  localparam int SHOW_LIMIT  = 10;

  class bst_scoreboard;
    logic signed [KEY_W-1:0] held_keys [KEY_SLOTS];
    logic signed [KEY_W-1:0] ranked [KEY_SLOTS];
    logic signed [KEY_W-1:0] level_key [SLOT_LIMIT];
    bit                      level_full [SLOT_LIMIT];
    int unsigned             held_count;
    bit                      overfull;
    out_t                    tree_q [$];
    int                      faults;
    int                      sets_built;
    int                      overfull_sets;
    int                      slots_checked;

    function int pending();
      return tree_q.size();
    endfunction

    function void fault(string what, out_t want, out_t got);
      faults++;
      if (faults <= SHOW_LIMIT) begin
        $display("mismatch (%s): want slot=%0d key=%0d present=%0b last=%0b",
                 what, want.slot, want.node_key, want.present, want.last_slot);
        $display("  got slot=%0d key=%0d present=%0b last=%0b",
                 got.slot, got.node_key, got.present, got.last_slot);
      end
    endfunction

    function void place_subtree(int lo, int size, int idx);
      int half;
      if (size == 0 || idx >= SLOT_LIMIT) begin
        return;
      end
      half = size / 2;
      level_key[idx]  = ranked[lo + half];
      level_full[idx] = 1'b1;
      place_subtree(lo, half, 2 * idx + 1);
      place_subtree(lo + half + 1, size - half - 1, 2 * idx + 2);
    endfunction

    function void note_key(in_t item);
      logic signed [KEY_W-1:0] v;
      int unsigned n;
      int unsigned j;
      int unsigned depth;
      int unsigned slots;
      out_t        want;
      if (held_count < KEY_SLOTS) begin
        held_keys[held_count] = item.key;
        held_count++;
      end else begin
        overfull = 1'b1;
      end
      if (!item.last_key) begin
        return;
      end
      n = held_count;
      for (int i = 0; i < n; i++) begin
        ranked[i] = held_keys[i];
      end
      for (int i = 1; i < n; i++) begin
        v = ranked[i];
        j = i;
        while (j > 0 && v < ranked[j - 1]) begin
          ranked[j] = ranked[j - 1];
          j--;
        end
        ranked[j] = v;
      end
      depth = 0;
      for (int unsigned k = n; k > 1; k = k / 2) begin
        depth++;
      end
      slots = (1 << (depth + 1)) - 1;
      if (slots > SLOT_LIMIT) begin
        slots = SLOT_LIMIT;
      end
      for (int i = 0; i < SLOT_LIMIT; i++) begin
        level_key[i]  = '0;
        level_full[i] = 1'b0;
      end
      place_subtree(0, n, 0);
      for (int i = 0; i < slots; i++) begin
        want.slot      = CNT_W'(i);
        want.node_key  = level_full[i] ? level_key[i] : '0;
        want.present   = level_full[i];
        want.last_slot = (i + 1 == slots);
        tree_q.push_back(want);
      end
      sets_built++;
      if (overfull) begin
        overfull_sets++;
      end
      held_count = 0;
      overfull   = 1'b0;
    endfunction

    function void check_slot(out_t got);
      out_t want;
      if (tree_q.size() == 0) begin
        fault("unexpected", '0, got);
        return;
      end
      want = tree_q.pop_front();
      slots_checked++;
      if (got.slot !== want.slot || got.node_key !== want.node_key ||
          got.present !== want.present || got.last_slot !== want.last_slot) begin
        fault("field", want, got);
      end
    endfunction
  endclass

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  bst_scoreboard sb = new;
  int  idle_cycles = 0;
  int  items_sent  = 0;
  int  burst_left  = 0;
  bit  held_off    = 1'b0;

  balanced_bst_level_order_builder_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        sb.check_slot(out_data_o);
      end
      if (in_valid_i && !in_stall_o) begin
        sb.note_key(in_data_i);
      end
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic logic signed [KEY_W-1:0] rand_key();
    case ($urandom_range(0, 7))
      0, 1: rand_key = $signed(KEY_W'($urandom_range(0, 8))) - 4;
      2: begin
        case ($urandom_range(0, 3))
          0: rand_key = 32'sh8000_0000;
          1: rand_key = 32'sh7fff_ffff;
          2: rand_key = '0;
          default: rand_key = '1;
        endcase
      end
      default: rand_key = $urandom();
    endcase
  endfunction

  // call at a falling edge; returns at the falling edge after the transfer
  task automatic send_key(input logic signed [KEY_W-1:0] key, input bit last);
    in_valid_i <= 1'b1;
    in_data_i  <= '{key: key, last_key: last};
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic pace(input bit drain);
    if (drain || burst_left == 0) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '{key: $urandom(), last_key: 1'($urandom_range(0, 1))};
      while (sb.pending() != 0) begin
        if (!drain) begin
          break;
        end
        @(negedge clk_i);
      end
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_set(input int size, input bit drain_after);
    for (int i = 0; i < size; i++) begin
      send_key(rand_key(), i == size - 1);
      pace(drain_after && i == size - 1);
    end
  endtask

  initial begin : receiver
    int span;
    int mode;
    span = 0;
    mode = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held_off && sb.slots_checked >= 120) begin
        held_off = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(16, 96);
        end
        span--;
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= 1'($urandom_range(0, 1));
          2: out_stall_i <= ($urandom_range(0, 7) == 0);
          default: out_stall_i <= ($urandom_range(0, 15) < 12);
        endcase
      end
    end
  end

  initial begin : sender
    logic signed [KEY_W-1:0] mixed [8];
    int set_idx;
    int size;
    mixed = '{32'sh0, -32'sd1, 32'sh8000_0000, 32'sh7fff_ffff,
              32'sd1, -32'sd1, 32'sh5555_5555, 32'shaaaa_aaaa};
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_key(32'sh7fff_ffff, 1'b1);
    pace(1'b0);
    send_key(32'sh7fff_ffff, 1'b0);
    pace(1'b0);
    send_key(32'sh8000_0000, 1'b1);
    pace(1'b0);
    for (int i = 0; i < 3; i++) begin
      send_key(32'sd5, i == 2);
      pace(1'b0);
    end
    for (int i = 0; i < 8; i++) begin
      send_key(mixed[i], i == 7);
      pace(1'b0);
    end
    for (int i = 0; i < 7; i++) begin
      send_key(3 - i, i == 6);
      pace(1'b0);
    end

    set_idx = 0;
    while (items_sent < ITEM_TARGET) begin
      case (set_idx)
        0: size = KEY_SLOTS;
        1: size = KEY_SLOTS + 3;
        default: begin
          case ($urandom_range(0, 11))
            0: size = $urandom_range(KEY_SLOTS + 1, KEY_SLOTS + 4);
            1: size = KEY_SLOTS;
            2: size = $urandom_range(16, 31);
            default: size = $urandom_range(1, 9);
          endcase
        end
      endcase
      send_set(size, set_idx == 10);
      set_idx++;
    end

    // hold the input idle until every slot has been handed out
    pace(1'b1);
    repeat (END_GUARD) @(posedge clk_i);

    $display("%0d key transfers in %0d sets (%0d overfull), %0d slots checked",
             items_sent, sb.sets_built, sb.overfull_sets, sb.slots_checked);
    $display("long output hold-off applied: %0b, faults: %0d", held_off, sb.faults);
    if (sb.faults == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
